### rtl/csf_pkg.sv
`default_nettype none
package csf_pkg;

  localparam int unsigned ROOT_FRAC = 20;
  localparam int unsigned PREF_FRAC = 24;
  localparam logic [21:0] PREF_Q24 = 22'd2965821;

  localparam logic [2:0] CFG_ROWS = 3'd0;
  localparam logic [2:0] CFG_COLS = 3'd1;
  localparam logic [2:0] CFG_S11  = 3'd2;
  localparam logic [2:0] CFG_S12  = 3'd3;
  localparam logic [2:0] CFG_S21  = 3'd4;
  localparam logic [2:0] CFG_S22  = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam int unsigned CNT_W = 5;
  // stencil terms 0..21, then the center read
  localparam logic [CNT_W-1:0] TERM_CENTER = 5'd22;
  localparam logic [CNT_W-1:0] LOAD_AT     = 5'd29;

  typedef struct packed {
    logic             start;
    logic             mem_we;
    logic             issue;
    logic [CNT_W-1:0] k;
    logic             load_result;
    logic             load_range;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_range;
  } dp_stat_t;

  typedef logic [27:0] root1_t [32];
  typedef logic [27:0] root2_t [256];

  function automatic logic [27:0] root_q20(input logic [63:0] p);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = p << (2 * ROOT_FRAC);
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (x > res) res = res + 64'd1;
    return res[27:0];
  endfunction

  function automatic root1_t build_root1();
    root1_t t;
    for (int i = 0; i < 32; i++) t[i] = root_q20(64'(i));
    return t;
  endfunction

  // entry {x,y} holds sqrt(x*(x-1)*y); x and y are 4-bit indexes
  function automatic root2_t build_root2();
    root2_t t;
    int     x;
    int     y;
    for (int i = 0; i < 256; i++) begin
      x = i / 16;
      y = i % 16;
      t[i] = root_q20(64'(x * (x - 1) * y));
    end
    return t;
  endfunction

endpackage
`default_nettype wire

### rtl/csf_if.sv
`default_nettype none
interface csf_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [31:0] value;
  modport source (output valid, kind, row, col, value, input ready);
  modport sink (input valid, kind, row, col, value, output ready);
endinterface

interface csf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flexed_value;
  logic [1:0]         status;
  modport source (output valid, flexed_value, status, input ready);
  modport sink (input valid, flexed_value, status, output ready);
endinterface

interface csf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/csf_dp.sv
`default_nettype none
module csf_dp #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic [3:0]         row_i,
  input  wire logic [3:0]         col_i,
  input  wire logic signed [31:0] value_i,
  input  wire csf_pkg::ctl_cmd_t  cmd_i,
  output csf_pkg::dp_stat_t       stat_o,
  output logic signed [31:0]      flexed_value_o,
  output logic [1:0]              status_o
);
  import csf_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] G11 = 2'd0;
  localparam logic [1:0] G12 = 2'd1;
  localparam logic [1:0] G21 = 2'd2;
  localparam logic [1:0] G22 = 2'd3;

  localparam root1_t ROOT1 = build_root1();
  localparam root2_t ROOT2 = build_root2();

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  logic [4:0]         rows_q, cols_q;
  logic signed [31:0] gain_q [4];
  logic [4:0]         rows_eff, cols_eff;
  logic [4:0]         rr_q, cc_q;
  logic [3:0]         ra_q, ca_q;

  logic signed [31:0] mem [DEPTH];
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] rd_q;

  logic [5:0]         a6, b6, r6, c6, rn, cn;
  logic signed [7:0]  as8, bs8, mult;
  logic               en, use1;
  logic [1:0]         gsel;
  logic [4:0]         x, y;

  logic               v1_q, center1_q;
  logic signed [31:0] gain1_q;
  logic signed [7:0]  mult1_q;
  logic [27:0]        root1_q;

  logic               v2_q;
  logic signed [63:0] gp2_q;
  logic signed [31:0] w2_q;
  logic signed [31:0] coef_q;

  logic               v3_q, sat3_q;
  logic signed [31:0] t3_q, w3_q;
  logic signed [63:0] gp_r;

  logic               v4_q, sat4_q;
  logic signed [63:0] tw4_q;

  logic signed [47:0] acc_q;
  logic               sat_seen_q;

  logic signed [41:0] accc;
  logic signed [21:0] hi;
  logic signed [22:0] pref_s;
  logic signed [44:0] p_hi_q;
  logic [41:0]        p_lo_q;
  logic signed [63:0] sum_q, term_q, total;

  always_comb begin
    rows_eff = rows_q;
    if (rows_q == 5'd0) rows_eff = 5'd1;
    else if (7'(rows_q) > 7'(MAX_ROWS)) rows_eff = 5'(MAX_ROWS);
    cols_eff = cols_q;
    if (cols_q == 5'd0) cols_eff = 5'd1;
    else if (7'(cols_q) > 7'(MAX_COLS)) cols_eff = 5'(MAX_COLS);
    stat_o.in_range = ({1'b0, row_i} < rows_eff) && ({1'b0, col_i} < cols_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      for (int i = 0; i < 4; i++) gain_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS: rows_q    <= cfg_data_i[4:0];
        CFG_COLS: cols_q    <= cfg_data_i[4:0];
        CFG_S11:  gain_q[0] <= cfg_data_i;
        CFG_S12:  gain_q[1] <= cfg_data_i;
        CFG_S21:  gain_q[2] <= cfg_data_i;
        CFG_S22:  gain_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ra_q <= row_i;
      ca_q <= col_i;
      rr_q <= rows_eff;
      cc_q <= cols_eff;
    end
  end

  // stencil decode
  always_comb begin
    a6   = {2'b0, ra_q};
    b6   = {2'b0, ca_q};
    r6   = {1'b0, rr_q};
    c6   = {1'b0, cc_q};
    as8  = {4'b0, ra_q};
    bs8  = {4'b0, ca_q};
    en   = 1'b0;
    rn   = a6;
    cn   = b6;
    gsel = G11;
    mult = 8'sd0;
    use1 = 1'b1;
    x    = 5'(a6);
    y    = 5'd0;
    case (cmd_i.k)
      5'd0: begin
        en = a6 >= 6'd3; mult = 8'sd2; rn = a6 - 6'd3;
        use1 = 1'b0; x = 5'(a6); y = 5'(a6 - 6'd2);
      end
      5'd1: begin
        en = a6 + 6'd3 < r6; mult = -8'sd2; rn = a6 + 6'd3;
        use1 = 1'b0; x = 5'(a6 + 6'd3); y = 5'(a6 + 6'd1);
      end
      5'd2: begin
        en = a6 >= 6'd1; mult = 8'sd2 * bs8 - 8'sd4; rn = a6 - 6'd1; x = 5'(a6);
      end
      5'd3: begin
        en = a6 + 6'd1 < r6; mult = -8'sd2 * as8 - 8'sd6; rn = a6 + 6'd1;
        x = 5'(a6 + 6'd1);
      end
      5'd4: begin
        gsel = G12; en = b6 >= 6'd3; mult = -8'sd2; cn = b6 - 6'd3;
        use1 = 1'b0; x = 5'(b6); y = 5'(b6 - 6'd2);
      end
      5'd5: begin
        gsel = G12; en = b6 + 6'd3 < c6; mult = 8'sd2; cn = b6 + 6'd3;
        use1 = 1'b0; x = 5'(b6 + 6'd3); y = 5'(b6 + 6'd1);
      end
      5'd6: begin
        gsel = G12; en = b6 >= 6'd1; mult = -8'sd2 * as8 + 8'sd4; cn = b6 - 6'd1;
        x = 5'(b6);
      end
      5'd7: begin
        gsel = G12; en = b6 + 6'd1 < c6; mult = 8'sd2 * bs8 + 8'sd6; cn = b6 + 6'd1;
        x = 5'(b6 + 6'd1);
      end
      5'd8: begin
        gsel = G21; en = b6 >= 6'd3; mult = 8'sd1; cn = b6 - 6'd3;
        use1 = 1'b0; x = 5'(b6); y = 5'(b6 - 6'd2);
      end
      5'd9: begin
        gsel = G21; en = b6 + 6'd3 < c6; mult = -8'sd1; cn = b6 + 6'd3;
        use1 = 1'b0; x = 5'(b6 + 6'd3); y = 5'(b6 + 6'd1);
      end
      5'd10: begin
        gsel = G21; en = b6 >= 6'd1; mult = 8'sd2 * as8 + bs8 - 8'sd3;
        cn = b6 - 6'd1; x = 5'(b6);
      end
      5'd11: begin
        gsel = G21; en = (b6 >= 6'd1) && (a6 >= 6'd2); mult = 8'sd3;
        rn = a6 - 6'd2; cn = b6 - 6'd1; use1 = 1'b0; x = 5'(a6); y = 5'(b6);
      end
      5'd12: begin
        gsel = G21; en = (b6 >= 6'd1) && (a6 + 6'd2 < r6); mult = -8'sd1;
        rn = a6 + 6'd2; cn = b6 - 6'd1; use1 = 1'b0; x = 5'(a6 + 6'd2); y = 5'(b6);
      end
      5'd13: begin
        gsel = G21; en = b6 + 6'd1 < c6; mult = -(as8 + bs8 + 8'sd5);
        cn = b6 + 6'd1; x = 5'(b6 + 6'd1);
      end
      5'd14: begin
        gsel = G21; en = (b6 + 6'd1 < c6) && (a6 + 6'd2 < r6); mult = -8'sd3;
        rn = a6 + 6'd2; cn = b6 + 6'd1; use1 = 1'b0;
        x = 5'(a6 + 6'd2); y = 5'(b6 + 6'd1);
      end
      5'd15: begin
        gsel = G22; en = a6 >= 6'd3; mult = 8'sd1; rn = a6 - 6'd3;
        use1 = 1'b0; x = 5'(a6); y = 5'(a6 - 6'd2);
      end
      5'd16: begin
        gsel = G22; en = a6 + 6'd3 < r6; mult = -8'sd1; rn = a6 + 6'd3;
        use1 = 1'b0; x = 5'(a6 + 6'd3); y = 5'(a6 + 6'd1);
      end
      5'd17: begin
        gsel = G22; en = a6 >= 6'd1; mult = 8'sd2 * bs8 + as8 - 8'sd3;
        rn = a6 - 6'd1; x = 5'(a6);
      end
      5'd18: begin
        gsel = G22; en = (a6 >= 6'd1) && (b6 >= 6'd2); mult = 8'sd3;
        rn = a6 - 6'd1; cn = b6 - 6'd2; use1 = 1'b0; x = 5'(b6); y = 5'(a6);
      end
      5'd19: begin
        gsel = G22; en = (a6 >= 6'd1) && (b6 + 6'd2 < c6); mult = -8'sd1;
        rn = a6 - 6'd1; cn = b6 + 6'd2; use1 = 1'b0; x = 5'(b6 + 6'd2); y = 5'(a6);
      end
      5'd20: begin
        gsel = G22; en = a6 + 6'd1 < r6; mult = -(as8 + bs8 + 8'sd5);
        rn = a6 + 6'd1; x = 5'(a6 + 6'd1);
      end
      5'd21: begin
        gsel = G22; en = (a6 + 6'd1 < r6) && (b6 + 6'd2 < c6); mult = -8'sd3;
        rn = a6 + 6'd1; cn = b6 + 6'd2; use1 = 1'b0;
        x = 5'(b6 + 6'd2); y = 5'(a6 + 6'd1);
      end
      default: ;
    endcase
    wr_addr = AW'(13'({2'b0, row_i}) * 13'(MAX_COLS) + 13'({2'b0, col_i}));
    rd_addr = AW'(13'(rn) * 13'(MAX_COLS) + 13'(cn));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem[wr_addr] <= value_i;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      center1_q <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
    end else begin
      v1_q      <= cmd_i.issue && en;
      center1_q <= cmd_i.issue && (cmd_i.k == TERM_CENTER);
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
    end
  end

  always_comb begin
    gp_r   = rnd(gp2_q, FRAC_BITS);
    accc   = 42'(acc_q);
    if (acc_q > 48'sh0100_0000_0000) accc = 42'sh100_0000_0000;
    else if (acc_q < -48'sh0100_0000_0000) accc = -42'sh100_0000_0000;
    hi     = accc[41:20];
    pref_s = $signed({1'b0, PREF_Q24});
    total  = coef_q + term_q;
  end

  always_ff @(posedge clk_i) begin
    gain1_q <= gain_q[gsel];
    mult1_q <= mult;
    root1_q <= use1 ? ROOT1[x] : ROOT2[{x[3:0], y[3:0]}];

    gp2_q <= gain1_q * rd_q;
    w2_q  <= mult1_q * $signed({1'b0, root1_q});
    if (center1_q) coef_q <= rd_q;

    w3_q <= w2_q;
    if (gp_r > 64'sh7FFF_FFFF) begin
      t3_q <= 32'sh7FFF_FFFF; sat3_q <= 1'b1;
    end else if (gp_r < -64'sh8000_0000) begin
      t3_q <= -32'sh8000_0000; sat3_q <= 1'b1;
    end else begin
      t3_q <= 32'(gp_r); sat3_q <= 1'b0;
    end

    tw4_q  <= t3_q * w3_q;
    sat4_q <= sat3_q;

    if (cmd_i.start) begin
      acc_q      <= '0;
      sat_seen_q <= 1'b0;
    end else if (v4_q) begin
      acc_q      <= acc_q + 48'(rnd(tw4_q, ROOT_FRAC));
      sat_seen_q <= sat_seen_q | sat4_q;
    end

    p_hi_q <= hi * pref_s;
    p_lo_q <= accc[19:0] * PREF_Q24;
    sum_q  <= (64'(p_hi_q) <<< 20) + 64'(p_lo_q);
    term_q <= -rnd(sum_q, PREF_FRAC);

    if (cmd_i.load_range) begin
      flexed_value_o <= '0;
      status_o       <= STATUS_RANGE;
    end else if (cmd_i.load_result) begin
      if (total > 64'sh7FFF_FFFF) begin
        flexed_value_o <= 32'sh7FFF_FFFF; status_o <= STATUS_SAT;
      end else if (total < -64'sh8000_0000) begin
        flexed_value_o <= -32'sh8000_0000; status_o <= STATUS_SAT;
      end else begin
        flexed_value_o <= 32'(total);
        status_o       <= sat_seen_q ? STATUS_SAT : STATUS_OK;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/csf_ctrl.sv
`default_nettype none
module csf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_kind_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire csf_pkg::dp_stat_t stat_i,
  output csf_pkg::ctl_cmd_t      cmd_o
);
  import csf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_RANGE} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept, slot_free;

  always_comb begin
    in_ready_o        = state_q == ST_IDLE;
    accept            = in_valid_i && in_ready_o;
    slot_free         = !out_valid_q || out_ready_i;
    cmd_o.start       = accept && stat_i.in_range && (in_kind_i == KIND_READ);
    cmd_o.mem_we      = accept && stat_i.in_range && (in_kind_i == KIND_WRITE);
    cmd_o.issue       = (state_q == ST_RUN) && (cnt_q <= TERM_CENTER);
    cmd_o.k           = cnt_q;
    cmd_o.load_result = (state_q == ST_RUN) && (cnt_q == LOAD_AT) && slot_free;
    cmd_o.load_range  = (state_q == ST_RANGE) && slot_free;
    out_valid_o       = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_result || cmd_o.load_range) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept && !stat_i.in_range) state_q <= ST_RANGE;
          else if (cmd_o.start) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (cnt_q != LOAD_AT) cnt_q <= cnt_q + 1'b1;
          if (cmd_o.load_result) state_q <= ST_IDLE;
        end
        ST_RANGE: begin
          if (cmd_o.load_range) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_result || cmd_o.load_range) |-> slot_free)
    else $error("result loaded over a pending item");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("read did not start the term sequence");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.mem_we, cmd_o.issue, cmd_o.load_result,
              cmd_o.load_range}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

### rtl/cartesian_shapelet_flexion.sv
// Cartesian shapelet flexion block.
// in_chan carries items: kind (write or read), row, col and a Q16.16 value.
// A write stores the coefficient and returns nothing; a read returns the
// coefficient plus its flexion term on out_chan with a status code.
// An item whose row or col is outside the rows/columns in use returns
// value 0 with the range status and changes nothing.
// cfg_chan writes rows_in_use, cols_in_use and the four gains; it is always
// ready and is meant to be written only while the block is idle.
// A write is stored when it is accepted. After a read is accepted, no new
// item is taken until its result is loaded into the output register:
// the stencil terms and the center go one per cycle through a single gain
// multiply, weight multiply and accumulate pipeline with one memory read
// port, followed by the scaling stages. An out-of-range item bypasses the
// pipeline and answers from a range state when the output register is free.
// One output register holds the result; when the receiver stalls, the
// block finishes the item and waits with in_chan ready low until that
// register is free. Reset clears the controller, the registers to their
// defaults (16 rows, 16 columns, zero gains); the store is not cleared.
`default_nettype none
module cartesian_shapelet_flexion #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int FRAC_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  csf_in_if.sink   in_chan,
  csf_out_if.source out_chan,
  csf_cfg_if.sink  cfg_chan
);
  import csf_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  csf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_kind_i   (in_chan.kind),
    .in_ready_o  (in_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  csf_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_chan.valid),
    .cfg_index_i    (cfg_chan.index),
    .cfg_data_i     (cfg_chan.data),
    .row_i          (in_chan.row),
    .col_i          (in_chan.col),
    .value_i        (in_chan.value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .flexed_value_o (out_chan.flexed_value),
    .status_o       (out_chan.status)
  );

endmodule
`default_nettype wire

### tb/csf_flexion_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module csf_flexion_checker
  import csf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csf_in_if         in_chan,
  csf_out_if        out_chan,
  csf_cfg_if        cfg_chan,
  output int        pending_o,
  output int        errors_o
);

  typedef struct {
    logic signed [31:0] flexed;
    logic [1:0]         status;
  } flex_result_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint ACC_LIM = 64'sd1 << 40;

  logic signed [31:0] coef_mem [256];
  logic [4:0]         rows_q;
  logic [4:0]         cols_q;
  logic signed [31:0] gain_q [4];
  longint             acc;
  bit                 term_sat;
  flex_result_t       expected_q[$];
  int                 errors;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // nearest integer to sqrt(p) * 2^20
  function automatic longint root_weight(longint p);
    longint n;
    longint lo;
    longint hi;
    longint mid;
    n  = p << 40;
    lo = 0;
    hi = 64'sd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    if (n - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  function automatic void add_neighbor(int g, longint mult, longint p, int r, int c);
    longint t;
    t = round_shift(longint'(gain_q[g]) * longint'(coef_mem[(r * 16 + c) % 256]), 16);
    if (t > S32_MAX) begin
      t = S32_MAX; term_sat = 1;
    end else if (t < S32_MIN) begin
      t = S32_MIN; term_sat = 1;
    end
    acc += round_shift(t * (mult * root_weight(p)), 20);
  endfunction

  function automatic int clamp_dim(logic [4:0] v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic bit predict_flex(logic kind, int a, int b, logic signed [31:0] value,
                                      output flex_result_t res);
    int     nr;
    int     nc;
    longint total;
    nr = clamp_dim(rows_q);
    nc = clamp_dim(cols_q);
    res.flexed = '0;
    res.status = STATUS_OK;
    if (a >= nr || b >= nc) begin
      res.status = STATUS_RANGE;
      return 1;
    end
    if (kind == KIND_WRITE) begin
      coef_mem[a * 16 + b] = value;
      return 0;
    end
    acc = 0;
    term_sat = 0;
    if (a >= 3) add_neighbor(0, 2, a * (a - 1) * (a - 2), a - 3, b);
    if (a < nr - 3) add_neighbor(0, -2, (a + 1) * (a + 2) * (a + 3), a + 3, b);
    if (a >= 1) add_neighbor(0, 2 * (b - 2), a, a - 1, b);
    if (a < nr - 1) add_neighbor(0, -2 * (a + 3), a + 1, a + 1, b);

    if (b >= 3) add_neighbor(1, -2, b * (b - 1) * (b - 2), a, b - 3);
    if (b < nc - 3) add_neighbor(1, 2, (b + 1) * (b + 2) * (b + 3), a, b + 3);
    if (b >= 1) add_neighbor(1, -2 * (a - 2), b, a, b - 1);
    if (b < nc - 1) add_neighbor(1, 2 * (b + 3), b + 1, a, b + 1);

    if (b >= 3) add_neighbor(2, 1, b * (b - 1) * (b - 2), a, b - 3);
    if (b < nc - 3) add_neighbor(2, -1, (b + 1) * (b + 2) * (b + 3), a, b + 3);
    if (b >= 1) begin
      add_neighbor(2, 2 * a + b - 3, b, a, b - 1);
      if (a >= 2) add_neighbor(2, 3, a * (a - 1) * b, a - 2, b - 1);
      if (a < nr - 2) add_neighbor(2, -1, (a + 1) * (a + 2) * b, a + 2, b - 1);
    end
    if (b < nc - 1) begin
      add_neighbor(2, -(a + b + 5), b + 1, a, b + 1);
      if (a < nr - 2) add_neighbor(2, -3, (a + 1) * (a + 2) * (b + 1), a + 2, b + 1);
    end

    if (a >= 3) add_neighbor(3, 1, a * (a - 1) * (a - 2), a - 3, b);
    if (a < nr - 3) add_neighbor(3, -1, (a + 1) * (a + 2) * (a + 3), a + 3, b);
    if (a >= 1) begin
      add_neighbor(3, 2 * b + a - 3, a, a - 1, b);
      if (b >= 2) add_neighbor(3, 3, b * (b - 1) * a, a - 1, b - 2);
      if (b < nc - 2) add_neighbor(3, -1, (b + 1) * (b + 2) * a, a - 1, b + 2);
    end
    if (a < nr - 1) begin
      add_neighbor(3, -(a + b + 5), a + 1, a + 1, b);
      if (b < nc - 2) add_neighbor(3, -3, (b + 1) * (b + 2) * (a + 1), a + 1, b + 2);
    end

    if (acc > ACC_LIM) acc = ACC_LIM;
    if (acc < -ACC_LIM) acc = -ACC_LIM;
    total = longint'(coef_mem[a * 16 + b]) - round_shift(acc * longint'(PREF_Q24), 24);
    if (total > S32_MAX) begin
      total = S32_MAX; term_sat = 1;
    end else if (total < S32_MIN) begin
      total = S32_MIN; term_sat = 1;
    end
    res.flexed = total[31:0];
    res.status = term_sat ? STATUS_SAT : STATUS_OK;
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    flex_result_t res;
    flex_result_t got;
    if (!rst_ni) begin
      rows_q <= 5'd16;
      cols_q <= 5'd16;
      for (int i = 0; i < 4; i++) gain_q[i] = '0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_ROWS: rows_q <= cfg_chan.data[4:0];
          CFG_COLS: cols_q <= cfg_chan.data[4:0];
          CFG_S11:  gain_q[0] = cfg_chan.data;
          CFG_S12:  gain_q[1] = cfg_chan.data;
          CFG_S21:  gain_q[2] = cfg_chan.data;
          CFG_S22:  gain_q[3] = cfg_chan.data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        if (predict_flex(in_chan.kind, int'(in_chan.row), int'(in_chan.col),
                         in_chan.value, res))
          expected_q.push_back(res);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.flexed = out_chan.flexed_value;
        got.status = out_chan.status;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h status %0d", $time,
                   got.flexed, got.status);
        end else begin
          res = expected_q.pop_front();
          if (got.flexed !== res.flexed) begin
            errors++;
            $display("%0t: flexed_value expected %h actual %h", $time, res.flexed,
                     got.flexed);
          end
          if (got.status !== res.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, res.status,
                     got.status);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

### tb/tb_cartesian_shapelet_flexion.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_cartesian_shapelet_flexion;
  import csf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   pending;
  int   errors;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   nrows = 16;
  int   ncols = 16;

  csf_in_if  in_if();
  csf_out_if out_if();
  csf_cfg_if cfg_if();

  always #5 clk_i = ~clk_i;

  cartesian_shapelet_flexion dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  csf_flexion_checker checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_chan  (cfg_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic kind, int r, int c, logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.kind  = kind;
    in_if.row   = r[3:0];
    in_if.col   = c[3:0];
    in_if.value = v;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [4:0] r, logic [4:0] c, logic [31:0] g11,
                            logic [31:0] g12, logic [31:0] g21, logic [31:0] g22);
    logic [31:0] vals [6];
    logic [2:0]  idx [6];
    drain();
    vals = '{32'(r), 32'(c), g11, g12, g21, g22};
    idx  = '{CFG_ROWS, CFG_COLS, CFG_S11, CFG_S12, CFG_S21, CFG_S22};
    for (int i = 0; i < 6; i++) begin
      cfg_if.index = idx[i];
      cfg_if.data  = vals[i];
      cfg_if.valid = 1'b1;
      do @(posedge clk_i); while (!cfg_if.ready);
      @(negedge clk_i);
    end
    cfg_if.valid = 1'b0;
    nrows = (r < 1) ? 1 : (r > 16) ? 16 : int'(r);
    ncols = (c < 1) ? 1 : (c > 16) ? 16 : int'(c);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(32'h3fffff)) - 32'sh1fffff);
    endcase
  endfunction

  function automatic logic [4:0] rand_dim();
    case ($urandom_range(7))
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2, 3: return 5'd16;
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic rand_items(int count);
    int r;
    int c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        r = $urandom_range(nrows - 1);
        c = $urandom_range(ncols - 1);
      end else begin
        r = $urandom_range(15);
        c = $urandom_range(15);
      end
      send_item(($urandom_range(99) < 40) ? KIND_WRITE : KIND_READ, r, c, rand_coef());
    end
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_WRITE;
    in_if.row    = '0;
    in_if.col    = '0;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ROWS;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill the whole store so that no read ever touches an unwritten entry
    for (int i = 0; i < 256; i++) send_item(KIND_WRITE, i / 16, i % 16, rand_coef());

    write_regs(5'd16, 5'd16, 32'h0001_0000, 32'hffff_8000, 32'h0000_4000, 32'h0002_0000);
    send_item(KIND_WRITE, 0, 0, 32'h7fff_ffff);
    send_item(KIND_WRITE, 15, 15, 32'h8000_0000);
    send_item(KIND_READ, 0, 0, '0);
    send_item(KIND_READ, 15, 15, '0);
    send_item(KIND_READ, 0, 15, '0);
    send_item(KIND_READ, 15, 0, '0);
    send_item(KIND_READ, 7, 8, '0);
    write_regs(5'd4, 5'd5, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(KIND_READ, 3, 4, '0);
    send_item(KIND_READ, 1, 2, '0);
    send_item(KIND_WRITE, 4, 0, 32'h1234_5678);
    send_item(KIND_READ, 0, 5, '0);
    send_item(KIND_WRITE, 15, 15, 32'h0000_0001);
    write_regs(5'd0, 5'd31, '0, '0, '0, '0);
    send_item(KIND_READ, 0, 9, '0);
    send_item(KIND_READ, 1, 0, '0);
    write_regs(5'd31, 5'd0, 32'h0000_8000, 32'h0001_0000, 32'hffff_0000, 32'h0000_0100);
    send_item(KIND_READ, 14, 0, '0);
    send_item(KIND_READ, 3, 1, '0);

    for (int ph = 0; ph < 4; ph++) begin
      write_regs(rand_dim(), rand_dim(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 31 : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 31 : 0;
      if (ph == 2) hold_req++;
      rand_items(97);
      if (ph == 3) drain();
      write_regs(rand_dim(), rand_dim(), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      rand_items(97);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
